// ----- hw/rtl/etb_pkg.sv -----
// Shared types and constants of the elimination tree builder.
package etb_pkg;

	localparam int MAX_NODES = 1024;
	localparam int NODE_W    = 10;
	localparam int COUNT_W   = 11;
	localparam int SIZE_W    = 8;
	localparam int ROWS_W    = 18;
	localparam int FILL_W    = 35;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 72;

	localparam logic [1:0] REQ_OPEN  = 2'd0;
	localparam logic [1:0] REQ_ENTRY = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	localparam logic [ROWS_W-1:0] ROWS_MAX = '1;

	// One node of the tree as held in the node store.
	typedef struct packed {
		logic                pvalid;
		logic [NODE_W-1:0]   parent;
		logic [NODE_W-1:0]   tag;
		logic [ROWS_W-1:0]   rcount;
		logic [SIZE_W-1:0]   bsize;
	} node_entry_t;

	typedef struct packed {
		logic                wr_en;
		logic [NODE_W-1:0]   wr_addr;
		node_entry_t         wr_data;
		logic                rd_en;
		logic [NODE_W-1:0]   rd_addr;
	} store_ctrl_t;

endpackage

// ----- hw/rtl/elimination_tree_builder_unit.sv -----
// Top level of the elimination tree builder: request decoding and path walking.
//
// Requests arrive on the s_ stream, one item at a time; s_tuser carries the kind
// (open column, row entry of the current column, read node). Only a read gives a
// result, on the m_ stream; opens and entries give none.
// Work per item; the node store has a single read port:
//   open         one store write.
//   row entry    one store read per node visited on the path to the root,
//                counting the node that already carries the current tag.
//   read         store read, two fill stages (multiply, then add), output
//                register; the result becomes valid in the same cycle as the
//                input is ready again.
// Each walk step reads the next node while it writes back the present one;
// parents always have higher indices, so the two never touch the same entry.
// Reset clears the column counters and the output valid; the node store is
// not cleared, and only nodes already opened are ever read back.
// When the receiver stalls, the result waits in the output register; further
// opens and entries are still taken, and the next read holds before its result.
module elimination_tree_builder_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// node_index [9:0], block_size [17:10], zeros above
	input  logic [etb_pkg::IN_DATA_W-1:0]      s_tdata,
	// req_type [1:0]
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// has_parent [0], parent_node [10:1], row_count [28:11],
	// node_block_size [36:29], fill [71:37]
	output logic [etb_pkg::OUT_DATA_W-1:0]     m_tdata,
	// status [0]
	output logic [0:0]                         m_tuser
);
	import etb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_RD,
		ST_P1,
		ST_P2
	} state_t;

	state_t              state_q;
	logic [NODE_W-1:0]   cur_col_q;
	logic [COUNT_W-1:0]  cols_q;
	logic [SIZE_W-1:0]   cur_size_q;
	logic [NODE_W-1:0]   walk_idx_q;
	logic                status_q;
	logic                hp_q;
	logic [NODE_W-1:0]   parent_q;
	logic [ROWS_W-1:0]   rows_q;
	logic [SIZE_W-1:0]   bsize_q;
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                out_status_q;

	store_ctrl_t         sctrl;
	node_entry_t         rd_data;
	logic                fill_go;
	logic                fill_valid;
	logic [FILL_W-1:0]   fill;

	logic                accept;
	logic [1:0]          req;
	logic [NODE_W-1:0]   idx;
	logic [SIZE_W-1:0]   bs;
	logic                read_miss;
	logic                entry_ok;
	logic                tag_hit;
	logic [NODE_W-1:0]   next_idx;
	logic                next_go;
	logic [ROWS_W:0]     rc_sum;
	logic [ROWS_W-1:0]   rc_new;
	logic                out_free;

	assign req   = s_tuser;
	assign idx   = s_tdata[NODE_W-1:0];
	assign bs    = s_tdata[NODE_W+SIZE_W-1:NODE_W];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign read_miss = ({1'b0, idx} >= cols_q);
	assign entry_ok  = (cols_q != '0) && (idx < cur_col_q);

	assign tag_hit  = (rd_data.tag == cur_col_q);
	assign next_idx = rd_data.pvalid ? rd_data.parent : cur_col_q;
	assign next_go  = (next_idx < cur_col_q);
	assign rc_sum   = {1'b0, rd_data.rcount} + {{(ROWS_W+1-SIZE_W){1'b0}}, cur_size_q};
	assign rc_new   = rc_sum[ROWS_W] ? ROWS_MAX : rc_sum[ROWS_W-1:0];
	assign out_free = !out_valid_q || m_tready;
	assign fill_go  = (state_q == ST_RD);

	always_comb begin
		sctrl = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && req == REQ_OPEN && !cols_q[COUNT_W-1]) begin
					sctrl.wr_en          = 1'b1;
					sctrl.wr_addr        = cols_q[NODE_W-1:0];
					sctrl.wr_data.tag    = cols_q[NODE_W-1:0];
					sctrl.wr_data.bsize  = bs;
				end
				if (accept && req == REQ_ENTRY && entry_ok) begin
					sctrl.rd_en   = 1'b1;
					sctrl.rd_addr = idx;
				end
				if (accept && req == REQ_READ && !read_miss) begin
					sctrl.rd_en   = 1'b1;
					sctrl.rd_addr = idx;
				end
			end
			ST_WALK: begin
				if (!tag_hit) begin
					sctrl.wr_en          = 1'b1;
					sctrl.wr_addr        = walk_idx_q;
					sctrl.wr_data.pvalid = 1'b1;
					sctrl.wr_data.parent = next_idx;
					sctrl.wr_data.tag    = cur_col_q;
					sctrl.wr_data.rcount = rc_new;
					sctrl.wr_data.bsize  = rd_data.bsize;
					sctrl.rd_en          = next_go;
					sctrl.rd_addr        = next_idx;
				end
			end
			default: begin
				sctrl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cur_col_q    <= '0;
			cols_q       <= '0;
			cur_size_q   <= '0;
			walk_idx_q   <= '0;
			status_q     <= 1'b0;
			hp_q         <= 1'b0;
			parent_q     <= '0;
			rows_q       <= '0;
			bsize_q      <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
			out_status_q <= 1'b0;
		end else begin
			if (state_q == ST_P2 && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req)
							REQ_OPEN: begin
								if (!cols_q[COUNT_W-1]) begin
									cur_col_q  <= cols_q[NODE_W-1:0];
									cur_size_q <= bs;
									cols_q     <= cols_q + {{(COUNT_W-1){1'b0}}, 1'b1};
								end
							end
							REQ_ENTRY: begin
								if (entry_ok) begin
									walk_idx_q <= idx;
									state_q    <= ST_WALK;
								end
							end
							REQ_READ: begin
								status_q <= read_miss;
								state_q  <= ST_RD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WALK: begin
					if (tag_hit || !next_go) begin
						state_q <= ST_IDLE;
					end else begin
						walk_idx_q <= next_idx;
					end
				end
				ST_RD: begin
					hp_q    <= rd_data.pvalid;
					parent_q <= rd_data.pvalid ? rd_data.parent : '0;
					rows_q  <= rd_data.rcount;
					bsize_q <= rd_data.bsize;
					state_q <= ST_P1;
				end
				ST_P1: begin
					state_q <= ST_P2;
				end
				ST_P2: begin
					if (out_free) begin
						out_status_q <= status_q;
						if (status_q) begin
							out_data_q <= '0;
						end else begin
							out_data_q <= {fill, bsize_q, rows_q, parent_q, hp_q};
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	etb_store u_store (
		.clk     (clk),
		.ctrl    (sctrl),
		.rd_data (rd_data)
	);

	etb_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (fill_go),
		.rows   (rd_data.rcount),
		.bsize  (rd_data.bsize),
		.valid  (fill_valid),
		.fill   (fill)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	// A write-back and the next walk read never hit the same entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		sctrl.wr_en && sctrl.rd_en |-> sctrl.wr_addr != sctrl.rd_addr)
		else $error("store read and write collide");

	// The walk only ever visits nodes below the current column.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> walk_idx_q < cur_col_q)
		else $error("walk left the columns below the current one");

	// The fill result is ready when the output stage picks it up.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_P2 |-> fill_valid || $past(state_q == ST_P2))
		else $error("fill not ready at output stage");

	// The column count never passes the store depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		cols_q <= COUNT_W'(MAX_NODES))
		else $error("column count beyond store depth");

	// A result is only loaded once the previous one has gone.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !m_tready |=> out_valid_q && $stable(out_data_q))
		else $error("pending result overwritten");

endmodule

// ----- hw/rtl/etb_store.sv -----
// Node store: one write port, one read port with registered read data.
module etb_store (
	input  logic                 clk,
	input  etb_pkg::store_ctrl_t ctrl,
	output etb_pkg::node_entry_t rd_data
);
	import etb_pkg::*;

	node_entry_t mem [MAX_NODES];

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= ctrl.wr_data;
		end
		if (ctrl.rd_en) begin
			rd_data <= mem[ctrl.rd_addr];
		end
	end

endmodule

// ----- hw/rtl/etb_fill.sv -----
// Two-stage fill calculation: rows*size + rows*(rows+1)/2.
module etb_fill (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [etb_pkg::ROWS_W-1:0]  rows,
	input  logic [etb_pkg::SIZE_W-1:0]  bsize,
	output logic                        valid,
	output logic [etb_pkg::FILL_W-1:0]  fill
);
	import etb_pkg::*;

	logic                      go_s1;
	logic                      go_s2;
	logic [ROWS_W+SIZE_W-1:0]  rs_s1;
	logic [2*ROWS_W:0]         rr_s1;
	logic [FILL_W-1:0]         fill_s2;
	logic [ROWS_W:0]           rows_inc;
	logic [2*ROWS_W:0]         sum;

	assign rows_inc = {1'b0, rows} + {{ROWS_W{1'b0}}, 1'b1};
	assign sum = {{(2*ROWS_W+1-ROWS_W-SIZE_W){1'b0}}, rs_s1} + {1'b0, rr_s1[2*ROWS_W:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
			go_s2 <= 1'b0;
		end else begin
			go_s1 <= go;
			go_s2 <= go_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rs_s1 <= rows * bsize;
			rr_s1 <= {1'b0, rows} * rows_inc;
		end
		if (go_s1) begin
			fill_s2 <= sum[FILL_W-1:0];
		end
	end

	assign valid = go_s2;
	assign fill  = fill_s2;

endmodule
